// ===== hw/rtl/tkfc_pkg.sv =====
// Shared types, constants and helper functions of the touch keypad LED flood controller.
`default_nettype none

package tkfc_pkg;

    localparam int MAP_W         = 12;
    localparam int KEY_W         = 4;
    localparam int TICK_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int LED_COUNT_DEF = 12;

    localparam logic [TICK_W-1:0] CONFIRM_RST = 16'd500;
    localparam logic [TICK_W-1:0] FLOOD_RST   = 16'd500;
    localparam logic [TICK_W-1:0] POWER_RST   = 16'd1;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_BUTTON = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONFIRM = 2'd0,
        REG_FLOOD   = 2'd1,
        REG_POWER   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_kind            kind;
        logic [MAP_W-1:0] touch_map;
        logic             button_down;
    } t_item;

    typedef struct packed {
        logic [MAP_W-1:0] led_level;
        logic             power_ind;
        logic [KEY_W-1:0] pressed_key;
        logic             all_lit;
    } t_result;

    typedef struct packed {
        logic [TICK_W-1:0] confirm_ticks;
        logic [TICK_W-1:0] flood_ticks;
        logic [TICK_W-1:0] power_ticks;
    } t_cfg;

    function automatic logic [TICK_W-1:0] load_value(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic logic [KEY_W-1:0] lowest_key(input logic [MAP_W-1:0] m);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                k = KEY_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tkfc_in_if.sv =====
// Input word channel: valid, ready and the sensor event payload.
`default_nettype none

interface tkfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [tkfc_pkg::MAP_W-1:0] touch_map;
    logic                       button_down;

    modport source (output valid, output kind, output touch_map, output button_down,
                    input ready);
    modport sink   (input valid, input kind, input touch_map, input button_down,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tkfc_out_if.sv =====
// Output word channel: valid, ready and the LED status payload.
`default_nettype none

interface tkfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [tkfc_pkg::MAP_W-1:0] led_level;
    logic                       power_ind;
    logic [tkfc_pkg::KEY_W-1:0] pressed_key;
    logic                       all_lit;

    modport source (output valid, output led_level, output power_ind, output pressed_key,
                    output all_lit, input ready);
    modport sink   (input valid, input led_level, input power_ind, input pressed_key,
                    input all_lit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tkfc_cfg.sv =====
// Configuration register file for the confirm and power debounce and the flood step tick counts.
`default_nettype none

module tkfc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [tkfc_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [tkfc_pkg::TICK_W-1:0]    i_data,
    output tkfc_pkg::t_cfg                 o_cfg
);

    tkfc_pkg::t_cfg r_cfg;
    tkfc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (tkfc_pkg::t_reg_idx'(i_idx))
                tkfc_pkg::REG_CONFIRM: n_cfg.confirm_ticks = i_data;
                tkfc_pkg::REG_FLOOD:   n_cfg.flood_ticks   = i_data;
                tkfc_pkg::REG_POWER:   n_cfg.power_ticks   = i_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_ticks <= tkfc_pkg::CONFIRM_RST;
            r_cfg.flood_ticks   <= tkfc_pkg::FLOOD_RST;
            r_cfg.power_ticks   <= tkfc_pkg::POWER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/tkfc_core.sv =====
// Controller state and its combinational update for one event word.
`default_nettype none

module tkfc_core #(
    parameter int LED_COUNT = tkfc_pkg::LED_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tkfc_pkg::t_item   i_item,
    input  tkfc_pkg::t_cfg    i_cfg,
    output tkfc_pkg::t_result o_result
);

    localparam int EXT_W = (LED_COUNT > tkfc_pkg::MAP_W) ? LED_COUNT : tkfc_pkg::MAP_W;
    localparam logic [LED_COUNT-1:0] LED_MASK = '1;

    logic [tkfc_pkg::MAP_W-1:0]  r_stored_map, n_stored_map;
    logic [LED_COUNT-1:0]        r_led,        n_led;
    logic [LED_COUNT-1:0]        r_pins,       n_pins;
    logic                        r_all_on,     n_all_on;
    logic                        r_power,      n_power;
    logic [tkfc_pkg::KEY_W-1:0]  r_key,        n_key;
    logic [tkfc_pkg::TICK_W-1:0] r_confirm,    n_confirm;
    logic [tkfc_pkg::TICK_W-1:0] r_flood,      n_flood;
    logic [tkfc_pkg::TICK_W-1:0] r_power_cnt,  n_power_cnt;

    logic                 c_fire;
    logic                 f_fire;
    logic                 p_fire;
    logic [LED_COUNT-1:0] grown;
    logic [LED_COUNT-1:0] lit;
    logic [EXT_W-1:0]     map_ext;
    logic [EXT_W-1:0]     pins_ext;

    assign c_fire  = (r_confirm   == tkfc_pkg::TICK_W'(1));
    assign f_fire  = (r_flood     == tkfc_pkg::TICK_W'(1));
    assign p_fire  = (r_power_cnt == tkfc_pkg::TICK_W'(1));
    assign grown   = r_led | (r_led << 1) | (r_led >> 1);
    assign map_ext = EXT_W'(r_stored_map);
    assign lit     = map_ext[LED_COUNT-1:0];

    always_comb begin
        n_stored_map = r_stored_map;
        n_led        = r_led;
        n_pins       = r_pins;
        n_all_on     = r_all_on;
        n_power      = r_power;
        n_key        = r_key;
        n_confirm    = r_confirm;
        n_flood      = r_flood;
        n_power_cnt  = r_power_cnt;
        if (i_step) begin
            unique case (i_item.kind)
                tkfc_pkg::KIND_SAMPLE: begin
                    if (i_item.touch_map > r_stored_map) begin
                        n_key     = tkfc_pkg::lowest_key(i_item.touch_map);
                        n_confirm = tkfc_pkg::load_value(i_cfg.confirm_ticks);
                    end else if (i_item.touch_map < r_stored_map) begin
                        if (r_power) begin
                            n_pins = '0;
                        end
                        n_led     = '0;
                        n_confirm = '0;
                        n_flood   = '0;
                        n_all_on  = 1'b0;
                    end
                    n_stored_map = i_item.touch_map;
                end
                tkfc_pkg::KIND_TICK: begin
                    if (r_confirm != '0) begin
                        n_confirm = r_confirm - tkfc_pkg::TICK_W'(1);
                    end
                    if (r_flood != '0) begin
                        n_flood = r_flood - tkfc_pkg::TICK_W'(1);
                    end
                    if (r_power_cnt != '0) begin
                        n_power_cnt = r_power_cnt - tkfc_pkg::TICK_W'(1);
                    end
                    if (f_fire) begin
                        if (!r_all_on) begin
                            if (r_led == LED_MASK) begin
                                n_all_on = 1'b1;
                            end
                            if (r_power) begin
                                n_pins = r_pins | (grown & ~r_led);
                            end
                            n_led = grown;
                        end else if (r_led[0]) begin
                            if (r_power) begin
                                n_pins = '0;
                            end
                            n_led = '0;
                        end else begin
                            if (r_power) begin
                                n_pins = LED_MASK;
                            end
                            n_led = LED_MASK;
                        end
                        n_flood = tkfc_pkg::load_value(i_cfg.flood_ticks);
                    end
                    if (c_fire && (i_item.touch_map == r_stored_map)) begin
                        if (r_power) begin
                            n_pins = n_pins | lit;
                        end
                        n_led   = n_led | lit;
                        n_flood = tkfc_pkg::load_value(i_cfg.flood_ticks);
                    end
                    if (p_fire && i_item.button_down) begin
                        n_power = !r_power;
                    end
                end
                tkfc_pkg::KIND_BUTTON: begin
                    if (i_item.button_down) begin
                        n_power_cnt = tkfc_pkg::load_value(i_cfg.power_ticks);
                    end
                end
                tkfc_pkg::KIND_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_map <= '0;
            r_led        <= '0;
            r_pins       <= '0;
            r_all_on     <= 1'b0;
            r_power      <= 1'b1;
            r_key        <= '0;
            r_confirm    <= '0;
            r_flood      <= '0;
            r_power_cnt  <= '0;
        end else begin
            r_stored_map <= n_stored_map;
            r_led        <= n_led;
            r_pins       <= n_pins;
            r_all_on     <= n_all_on;
            r_power      <= n_power;
            r_key        <= n_key;
            r_confirm    <= n_confirm;
            r_flood      <= n_flood;
            r_power_cnt  <= n_power_cnt;
        end
    end

    assign pins_ext             = EXT_W'(n_pins);
    assign o_result.led_level   = pins_ext[tkfc_pkg::MAP_W-1:0];
    assign o_result.power_ind   = n_power;
    assign o_result.pressed_key = n_key;
    assign o_result.all_lit     = n_all_on;

endmodule

`default_nettype wire

// ===== hw/rtl/touch_keypad_led_flood_controller_unit.sv =====
// Top level of the touch keypad LED flood controller: input stage, state update, output stage.
//
//   channel   dir   handshake          payload
//   i_word    in    valid / ready      kind, touch_map, button_down
//   o_word    out   valid / ready      led_level, power_ind, pressed_key, all_lit
//   i_cfg_*   in    write enable only  i_cfg_idx, i_cfg_data
//
// One word per cycle unless the output stalls; each word is registered in both stages.
// The state update is a single pass over the registered input word.
// Synchronous reset clears both stages and loads the register defaults.
// A stalled output holds its word while one more input word waits in the input stage.
`default_nettype none

module touch_keypad_led_flood_controller_unit #(
    parameter int LED_COUNT = tkfc_pkg::LED_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tkfc_in_if.sink                        i_word,
    tkfc_out_if.source                     o_word,
    input  logic                           i_cfg_we,
    input  logic [tkfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tkfc_pkg::TICK_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    tkfc_pkg::t_item   r_in;
    logic              r_out_valid;
    tkfc_pkg::t_result r_out;

    logic              advance;
    tkfc_pkg::t_cfg    cfg;
    tkfc_pkg::t_result result;

    assign advance      = r_in_valid && (!r_out_valid || o_word.ready);
    assign i_word.ready = !r_in_valid || advance;

    tkfc_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    tkfc_core #(
        .LED_COUNT(LED_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_in.kind        <= tkfc_pkg::t_kind'(i_word.kind);
            r_in.touch_map   <= i_word.touch_map;
            r_in.button_down <= i_word.button_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.led_level   = r_out.led_level;
    assign o_word.power_ind   = r_out.power_ind;
    assign o_word.pressed_key = r_out.pressed_key;
    assign o_word.all_lit     = r_out.all_lit;

endmodule

`default_nettype wire

// ===== hw/rtl/tkfc_checker.sv =====
// Port-level assertions for the flood controller top level and their bind.
`default_nettype none

module tkfc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tkfc_pkg::MAP_W-1:0] i_led_level,
    input logic                       i_power_ind,
    input logic [tkfc_pkg::KEY_W-1:0] i_pressed_key,
    input logic                       i_all_lit
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_led_level)
            && $stable(i_power_ind) && $stable(i_pressed_key) && $stable(i_all_lit))
        else $error("stalled output word changed");

    a_word_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("output word without an input word two cycles before");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pressed_key <= tkfc_pkg::KEY_W'(tkfc_pkg::MAP_W))
        else $error("pressed key out of range");

endmodule

bind touch_keypad_led_flood_controller_unit tkfc_checker u_tkfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_word.valid),
    .i_in_ready   (i_word.ready),
    .i_out_valid  (o_word.valid),
    .i_out_ready  (o_word.ready),
    .i_led_level  (o_word.led_level),
    .i_power_ind  (o_word.power_ind),
    .i_pressed_key(o_word.pressed_key),
    .i_all_lit    (o_word.all_lit)
);

`default_nettype wire

// ===== bench/touch_keypad_led_flood_controller_unit_tb.sv =====
// Testbench for the touch keypad LED flood controller: driven words, predicted LED status, checks.
`default_nettype none

module touch_keypad_led_flood_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tkfc_pkg::MAP_W-1:0] ALL_LEDS    = '1;
    localparam int                         CYCLE_LIMIT = 200000;
    localparam int                         DRAIN_WAIT  = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tkfc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tkfc_pkg::TICK_W-1:0] i_cfg_data;

    tkfc_in_if  word_in ();
    tkfc_out_if word_out ();

    touch_keypad_led_flood_controller_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (word_in),
        .o_word     (word_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state and register copy
    tkfc_pkg::t_cfg             cfg;
    logic [tkfc_pkg::MAP_W-1:0] seen_map;
    logic [tkfc_pkg::MAP_W-1:0] lit_logic;
    logic [tkfc_pkg::MAP_W-1:0] pin_drive;
    logic                       blink_mode;
    logic                       power_up;
    logic [tkfc_pkg::KEY_W-1:0] key_latch;
    logic [16:0]                confirm_left;
    logic [16:0]                flood_left;
    logic [16:0]                power_left;

    tkfc_pkg::t_item   word_pending[$];
    tkfc_pkg::t_result led_status_q[$];
    logic [tkfc_pkg::MAP_W-1:0] gen_map;
    int      pushed_cnt;
    int      useful_cnt;
    int      accepted_cnt;
    int      err_cnt;
    int      cycle_cnt;
    logic    run_on;
    logic    quiet;
    logic    in_taken;
    int      send_gap;
    int      stall_left;

    function automatic logic [16:0] reload(input logic [tkfc_pkg::TICK_W-1:0] v);
        return (v == '0) ? 17'd1 : {1'b0, v};
    endfunction

    function automatic void drive_leds(input logic [tkfc_pkg::MAP_W-1:0] on_bits,
                                       input logic [tkfc_pkg::MAP_W-1:0] off_bits);
        if (power_up) begin
            pin_drive = (pin_drive | on_bits) & ~off_bits;
        end
    endfunction

    function automatic tkfc_pkg::t_result step_led_state(input tkfc_pkg::t_item w);
        tkfc_pkg::t_result          r;
        logic                       c_fire;
        logic                       f_fire;
        logic                       p_fire;
        logic [tkfc_pkg::MAP_W-1:0] old;
        logic [tkfc_pkg::MAP_W-1:0] grown;
        c_fire = 1'b0;
        f_fire = 1'b0;
        p_fire = 1'b0;
        case (w.kind)
            tkfc_pkg::KIND_SAMPLE: begin
                if (w.touch_map > seen_map) begin
                    for (int i = 0; i < tkfc_pkg::MAP_W; i++) begin
                        if (w.touch_map[i]) begin
                            key_latch = tkfc_pkg::KEY_W'(i + 1);
                            break;
                        end
                    end
                    confirm_left = reload(cfg.confirm_ticks);
                end else if (w.touch_map < seen_map) begin
                    drive_leds('0, ALL_LEDS);
                    lit_logic    = '0;
                    confirm_left = '0;
                    flood_left   = '0;
                    blink_mode   = 1'b0;
                end
                seen_map = w.touch_map;
            end
            tkfc_pkg::KIND_TICK: begin
                if (confirm_left != 0) begin
                    confirm_left--;
                    c_fire = (confirm_left == 0);
                end
                if (flood_left != 0) begin
                    flood_left--;
                    f_fire = (flood_left == 0);
                end
                if (power_left != 0) begin
                    power_left--;
                    p_fire = (power_left == 0);
                end
                if (f_fire) begin
                    if (!blink_mode) begin
                        old   = lit_logic;
                        grown = old | (old << 1) | (old >> 1);
                        if (old == ALL_LEDS) begin
                            blink_mode = 1'b1;
                        end
                        drive_leds(grown & ~old, '0);
                        lit_logic = grown;
                    end else if (lit_logic[0]) begin
                        drive_leds('0, ALL_LEDS);
                        lit_logic = '0;
                    end else begin
                        drive_leds(ALL_LEDS, '0);
                        lit_logic = ALL_LEDS;
                    end
                    flood_left = reload(cfg.flood_ticks);
                end
                if (c_fire && w.touch_map == seen_map) begin
                    drive_leds(seen_map, '0);
                    lit_logic  = lit_logic | seen_map;
                    flood_left = reload(cfg.flood_ticks);
                end
                if (p_fire && w.button_down) begin
                    power_up = !power_up;
                end
            end
            tkfc_pkg::KIND_BUTTON: begin
                if (w.button_down) begin
                    power_left = reload(cfg.power_ticks);
                end
            end
            default: begin
            end
        endcase
        r.led_level   = pin_drive;
        r.power_ind   = power_up;
        r.pressed_key = key_latch;
        r.all_lit     = blink_mode;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic push_word(input tkfc_pkg::t_kind k, input logic [tkfc_pkg::MAP_W-1:0] m,
                             input logic b);
        tkfc_pkg::t_item w;
        w.kind        = k;
        w.touch_map   = m;
        w.button_down = b;
        word_pending.push_back(w);
        pushed_cnt++;
        if (k != tkfc_pkg::KIND_NONE) begin
            useful_cnt++;
        end
        if (k == tkfc_pkg::KIND_SAMPLE) begin
            gen_map = m;
        end
    endtask

    task automatic write_reg(input tkfc_pkg::t_reg_idx idx,
                             input logic [tkfc_pkg::TICK_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            tkfc_pkg::REG_CONFIRM: cfg.confirm_ticks = v;
            tkfc_pkg::REG_FLOOD:   cfg.flood_ticks   = v;
            default:               cfg.power_ticks   = v;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timers(input logic [tkfc_pkg::TICK_W-1:0] c,
                              input logic [tkfc_pkg::TICK_W-1:0] f,
                              input logic [tkfc_pkg::TICK_W-1:0] p);
        write_reg(tkfc_pkg::REG_CONFIRM, c);
        write_reg(tkfc_pkg::REG_FLOOD, f);
        write_reg(tkfc_pkg::REG_POWER, p);
    endtask

    task automatic wait_drained();
        while (accepted_cnt != pushed_cnt || led_status_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic int tick_span(input logic [tkfc_pkg::TICK_W-1:0] v);
        return (v > 16'd40) ? 40 : int'(v);
    endfunction

    task automatic queue_random(input int target);
        int                         goal;
        int                         n;
        logic [tkfc_pkg::MAP_W-1:0] m;
        goal = useful_cnt + target;
        while (useful_cnt < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if (gen_map == ALL_LEDS || $urandom_range(0, 2) == 0) begin
                        push_word(tkfc_pkg::KIND_SAMPLE, '0, 1'($urandom_range(0, 1)));
                    end
                    m = gen_map + 12'd1 + 12'($urandom_range(0, 4094 - int'(gen_map)));
                    push_word(tkfc_pkg::KIND_SAMPLE, m, 1'($urandom_range(0, 1)));
                    n = tick_span(cfg.confirm_ticks) + $urandom_range(1, 70);
                    repeat (n) push_word(tkfc_pkg::KIND_TICK, m, 1'($urandom_range(0, 1)));
                end
                5: begin
                    if (gen_map != 0) begin
                        push_word(tkfc_pkg::KIND_SAMPLE,
                                  12'($urandom_range(0, int'(gen_map) - 1)),
                                  1'($urandom_range(0, 1)));
                    end else begin
                        push_word(tkfc_pkg::KIND_TICK, gen_map, 1'($urandom_range(0, 1)));
                    end
                end
                6: begin
                    push_word(tkfc_pkg::KIND_BUTTON, 12'($urandom),
                              ($urandom_range(0, 4) != 0));
                    n = tick_span(cfg.power_ticks) + $urandom_range(0, 3);
                    repeat (n) begin
                        push_word(tkfc_pkg::KIND_TICK, gen_map, ($urandom_range(0, 5) != 0));
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 5)) begin
                        push_word(tkfc_pkg::t_kind'($urandom_range(0, 3)), 12'($urandom),
                                  1'($urandom_range(0, 1)));
                    end
                end
                8: begin
                    repeat ($urandom_range(1, 6)) begin
                        push_word(tkfc_pkg::KIND_TICK, 12'($urandom),
                                  1'($urandom_range(0, 1)));
                    end
                end
                default: begin
                    push_word(tkfc_pkg::KIND_NONE, 12'($urandom), 1'($urandom_range(0, 1)));
                    push_word(tkfc_pkg::KIND_SAMPLE, gen_map, 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge i_clk) begin : mon
        tkfc_pkg::t_result got;
        tkfc_pkg::t_result want;
        tkfc_pkg::t_item   w;
        in_taken = i_rst_n && word_in.valid && word_in.ready;
        if (i_rst_n && word_out.valid && word_out.ready) begin
            got.led_level   = word_out.led_level;
            got.power_ind   = word_out.power_ind;
            got.pressed_key = word_out.pressed_key;
            got.all_lit     = word_out.all_lit;
            if (led_status_q.size() == 0) begin
                $display("%0t: word expected none actual %h", $time, got);
                err_cnt++;
            end else begin
                want = led_status_q.pop_front();
                check_field("led_level", 32'(want.led_level), 32'(got.led_level));
                check_field("power_ind", 32'(want.power_ind), 32'(got.power_ind));
                check_field("pressed_key", 32'(want.pressed_key), 32'(got.pressed_key));
                check_field("all_lit", 32'(want.all_lit), 32'(got.all_lit));
            end
        end
        if (in_taken) begin
            w.kind        = tkfc_pkg::t_kind'(word_in.kind);
            w.touch_map   = word_in.touch_map;
            w.button_down = word_in.button_down;
            led_status_q.push_back(step_led_state(w));
            accepted_cnt++;
        end
    end

    always @(negedge i_clk) begin : drv
        logic            nxt_valid;
        tkfc_pkg::t_item nxt;
        if (run_on && !(word_in.valid && !in_taken)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (word_pending.size() != 0) begin
                nxt       = word_pending.pop_front();
                nxt_valid = 1'b1;
                word_in.kind        <= nxt.kind;
                word_in.touch_map   <= nxt.touch_map;
                word_in.button_down <= nxt.button_down;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 14);
                end
            end
            word_in.valid <= nxt_valid;
        end
    end

    always @(negedge i_clk) begin : rcv
        if (stall_left > 0) begin
            stall_left--;
            word_out.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            word_out.ready <= 1'b0;
        end else begin
            word_out.ready <= 1'b1;
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("touch_keypad_led_flood_controller_unit_tb: errors");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = tkfc_pkg::REG_CONFIRM;
        i_cfg_data          = '0;
        word_in.valid       = 1'b0;
        word_in.kind        = tkfc_pkg::KIND_SAMPLE;
        word_in.touch_map   = '0;
        word_in.button_down = 1'b0;
        word_out.ready      = 1'b1;
        cfg          = '{tkfc_pkg::CONFIRM_RST, tkfc_pkg::FLOOD_RST, tkfc_pkg::POWER_RST};
        seen_map     = '0;
        lit_logic    = '0;
        pin_drive    = '0;
        blink_mode   = 1'b0;
        power_up     = 1'b1;
        key_latch    = '0;
        confirm_left = '0;
        flood_left   = '0;
        power_left   = '0;
        gen_map      = '0;
        pushed_cnt   = 0;
        useful_cnt   = 0;
        accepted_cnt = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        run_on       = 1'b0;
        quiet        = 1'b0;
        in_taken     = 1'b0;
        send_gap     = 0;
        stall_left   = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_on = 1'b1;

        set_timers(16'd1, 16'd1, 16'd0);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'h000, 1'b0);
        push_word(tkfc_pkg::KIND_NONE, 12'hABC, 1'b1);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'h840, 1'b0);
        repeat (9) push_word(tkfc_pkg::KIND_TICK, 12'h840, 1'b0);
        push_word(tkfc_pkg::KIND_BUTTON, 12'h840, 1'b0);
        push_word(tkfc_pkg::KIND_BUTTON, 12'h840, 1'b1);
        push_word(tkfc_pkg::KIND_TICK, 12'h840, 1'b1);
        push_word(tkfc_pkg::KIND_TICK, 12'h840, 1'b0);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'hFFF, 1'b0);
        push_word(tkfc_pkg::KIND_TICK, 12'h7FF, 1'b0);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'h000, 1'b0);
        push_word(tkfc_pkg::KIND_BUTTON, 12'h555, 1'b1);
        push_word(tkfc_pkg::KIND_TICK, 12'h000, 1'b0);
        push_word(tkfc_pkg::KIND_BUTTON, 12'h000, 1'b1);
        push_word(tkfc_pkg::KIND_TICK, 12'h000, 1'b1);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'hFFF, 1'b1);
        push_word(tkfc_pkg::KIND_TICK, 12'hFFF, 1'b0);
        push_word(tkfc_pkg::KIND_SAMPLE, 12'h001, 1'b0);
        wait_drained();

        queue_random(90);
        wait_drained();

        set_timers(16'd3, 16'd2, 16'd2);
        queue_random(90);
        wait_drained();

        set_timers(16'd0, 16'd0, 16'd0);
        quiet = 1'b1;
        queue_random(80);
        wait_drained();
        quiet = 1'b0;

        set_timers(16'd65535, 16'd65535, 16'd65535);
        queue_random(30);
        wait_drained();

        set_timers(16'd5, 16'd1, 16'd3);
        queue_random(90);
        wait_drained();

        set_timers(16'd2, 16'd1, 16'd1);
        quiet = 1'b1;
        queue_random(80);
        wait_drained();

        if (err_cnt == 0) begin
            $display("touch_keypad_led_flood_controller_unit_tb: clean");
        end else begin
            $display("touch_keypad_led_flood_controller_unit_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tkfc_pkg.sv
hw/rtl/tkfc_in_if.sv
hw/rtl/tkfc_out_if.sv
hw/rtl/tkfc_cfg.sv
hw/rtl/tkfc_core.sv
hw/rtl/touch_keypad_led_flood_controller_unit.sv
hw/rtl/tkfc_checker.sv
bench/touch_keypad_led_flood_controller_unit_tb.sv
